@@ hw/rtl/sapq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sapq_pkg
// shared types and codes of the sorted-array priority queue: transaction
// payloads, stored entry, controller states and the command/status bundles
// ----------------------------------------------------------------------------
package sapq_pkg;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// capacity register
	localparam int         CAP_W     = 5;
	localparam logic [4:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic               command;
		logic signed [31:0] item_value;
		logic signed [15:0] item_priority;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic signed [15:0] removed_priority;
		logic [4:0]         occupancy;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_DEL_HEAD_RD,
		S_DEL_HEAD,
		S_DEL_RD,
		S_DEL_WR,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RA_ZERO,
		RA_IDX,
		RA_IDX_M1
	} rd_addr_t;

	typedef struct packed {
		logic       capture;
		logic [1:0] res_code;
		logic       rd_en;
		rd_addr_t   rd_addr;
		logic       wr_en;
		logic       wr_at_prev;
		logic       wr_new;
		logic       idx_dec;
		logic       idx_inc;
		logic       take_head;
		logic       count_inc;
		logic       count_dec;
		logic       load_rsp;
	} dp_cmd_t;

	typedef struct packed {
		logic req_insert;
		logic count_zero;
		logic at_limit;
		logic idx_zero;
		logic idx_end;
		logic key_le;
	} dp_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/sapq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sapq_ctrl
// controller: sequences the slot moves of insert and delete, owns the
// request/response handshakes
// ----------------------------------------------------------------------------
module sapq_ctrl
	import sapq_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_ready,
	output logic         rsp_valid,
	input  wire logic    rsp_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign req_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (sts.req_insert) begin
						state_d = sts.at_limit ? S_FINISH : S_INS_RD;
					end else begin
						state_d = sts.count_zero ? S_FINISH : S_DEL_HEAD_RD;
					end
				end
			end
			S_INS_RD: begin
				state_d = sts.idx_zero ? S_FINISH : S_INS_CMP;
			end
			S_INS_CMP: begin
				state_d = sts.key_le ? S_FINISH : S_INS_RD;
			end
			S_DEL_HEAD_RD: state_d = S_DEL_HEAD;
			S_DEL_HEAD:    state_d = S_DEL_RD;
			S_DEL_RD: begin
				state_d = sts.idx_end ? S_FINISH : S_DEL_WR;
			end
			S_DEL_WR: state_d = S_DEL_RD;
			S_FINISH: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd          = '0;
		cmd.res_code = ST_DONE;
		cmd.rd_addr  = RA_ZERO;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					if (sts.req_insert && sts.at_limit) begin
						cmd.res_code = ST_FULL;
					end else if (!sts.req_insert && sts.count_zero) begin
						cmd.res_code = ST_EMPTY;
					end
				end
			end
			S_INS_RD: begin
				if (sts.idx_zero) begin
					cmd.wr_en     = 1'b1;
					cmd.wr_new    = 1'b1;
					cmd.count_inc = 1'b1;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = RA_IDX_M1;
				end
			end
			S_INS_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.key_le) begin
					cmd.wr_new    = 1'b1;
					cmd.count_inc = 1'b1;
				end else begin
					cmd.idx_dec = 1'b1;
				end
			end
			S_DEL_HEAD_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = RA_ZERO;
			end
			S_DEL_HEAD: cmd.take_head = 1'b1;
			S_DEL_RD: begin
				if (sts.idx_end) begin
					cmd.count_dec = 1'b1;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = RA_IDX;
				end
			end
			S_DEL_WR: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_at_prev = 1'b1;
				cmd.idx_inc    = 1'b1;
			end
			S_FINISH: cmd.load_rsp = rsp_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/sapq_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sapq_dpath
// datapath: sorted entry memory, slot index, count, capacity register and
// response register
// ----------------------------------------------------------------------------
module sapq_dpath
	import sapq_pkg::*;
#(
	parameter int DEPTH = 16
)(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire req_t             req,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata,
	input  wire dp_cmd_t          cmd,
	output dp_sts_t               sts,
	output rsp_t                  rsp
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	entry_t             mem_q [DEPTH];
	entry_t             rd_data_q;
	entry_t             new_q;
	entry_t             wr_data;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   idx_m1;
	logic [CNT_W-1:0]   count_q;
	logic [CAP_W-1:0]   cap_q;
	logic [1:0]         res_status_q;
	logic signed [31:0] res_value_q;
	logic signed [15:0] res_prio_q;
	rsp_t               rsp_q;
	logic [LW-1:0]      cnt_ext;
	logic [LW-1:0]      cap_ext;

	assign idx_m1  = idx_q - CNT_W'(1);
	assign cnt_ext = LW'(count_q);
	assign cap_ext = LW'(cap_q);

	always_comb begin
		unique case (cmd.rd_addr)
			RA_ZERO:   rd_addr = '0;
			RA_IDX:    rd_addr = idx_q[AW-1:0];
			RA_IDX_M1: rd_addr = idx_m1[AW-1:0];
			default:   rd_addr = '0;
		endcase
	end

	assign wr_addr = cmd.wr_at_prev ? idx_m1[AW-1:0] : idx_q[AW-1:0];
	assign wr_data = cmd.wr_new ? new_q : rd_data_q;

	// entry store, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			new_q.value  <= req.item_value;
			new_q.prio   <= req.item_priority;
			res_status_q <= cmd.res_code;
			res_value_q  <= '0;
			res_prio_q   <= '0;
		end
		if (cmd.take_head) begin
			res_value_q <= rd_data_q.value;
			res_prio_q  <= rd_data_q.prio;
		end
		if (cmd.load_rsp) begin
			rsp_q.status           <= res_status_q;
			rsp_q.removed_value    <= res_value_q;
			rsp_q.removed_priority <= res_prio_q;
			rsp_q.occupancy        <= 5'(count_q);
		end
		if (cmd.capture) begin
			idx_q <= (req.command == CMD_INSERT) ? count_q : CNT_W'(1);
		end else if (cmd.idx_dec) begin
			idx_q <= idx_m1;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.count_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign sts.req_insert = (req.command == CMD_INSERT);
	assign sts.count_zero = (count_q == '0);
	assign sts.at_limit   = (cnt_ext >= cap_ext) || (count_q >= CNT_W'(DEPTH));
	assign sts.idx_zero   = (idx_q == '0);
	assign sts.idx_end    = (idx_q >= count_q);
	assign sts.key_le     = ($signed(rd_data_q.prio) <= $signed(new_q.prio));

	assign rsp = rsp_q;

endmodule
`default_nettype wire

@@ hw/rtl/sorted_array_priority_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// min-first priority queue held as a sorted array in a single-port-write,
// registered-read memory
// ----------------------------------------------------------------------------
// Entries sit in ascending priority order in slots 0..count-1; equal
// priorities leave in arrival order. One transaction is worked at a time.
// An insert walks down from the rear, moving each entry with a larger
// priority up one slot. A delete reads slot 0, then moves the remaining
// n-1 entries down one slot for a queue of n. A full insert or an empty
// delete goes straight to the response without a memory access. Each
// move is a read step then a write step because the memory read data is
// registered, so the memory port sets the pace. The response register
// lets the next request be accepted while a response still waits. The
// capacity register may be written only while the queue is idle.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue
	import sapq_pkg::*;
#(
	parameter int DEPTH = 16
)(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request transaction
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire req_t             req,
	// response transaction
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output rsp_t                  rsp,
	// capacity register write
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer for slot moves and both handshakes
	sapq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// entry memory, count, capacity and response payload
	sapq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

	// a failed operation never returns entry data
	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_DONE) |->
			(rsp.removed_value == '0) && (rsp.removed_priority == '0))
		else $error("failed operation returned entry data");

	// an empty report only comes from an empty queue
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_EMPTY) |-> (rsp.occupancy == '0))
		else $error("empty status with nonzero occupancy");

	// the queue is not ready again in the cycle after it accepts a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous transaction in work");

endmodule
`default_nettype wire
